// ===== sv/sst_pkg.sv =====
// shared types and constants for the stream sequence tracker
`timescale 1ns / 1ps
`default_nettype none

package sst_pkg;

    // widths fixed by the stream fields
    localparam int ADDR_W = 32;
    localparam int TS_W   = 32;
    localparam int SEQ_W  = 16;
    localparam int LFSR_W = 32;

    // default table depth
    localparam int STREAM_ENTRIES_DEFAULT = 16;

    // galois lfsr feedback taps
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

    // seed value that replaces an all-zero seed
    localparam logic [LFSR_W-1:0] LFSR_NONZERO_SEED = 32'h0000_0001;

    // lookup token handed from cell to cell along the chain
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [TS_W-1:0]   timestamp;
        logic [TS_W-1:0]   next_timestamp;
        logic              marker;
        logic              done;
        logic              created;
        logic [SEQ_W-1:0]  seq_num;
    } sst_token_t;

endpackage

`default_nettype wire

// ===== sv/sst_cell.sv =====
// one table entry of the stream chain with its token stage
`timescale 1ns / 1ps
`default_nettype none

module sst_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sst_pkg::sst_token_t        tok_in,
    input  wire logic [sst_pkg::SEQ_W-1:0]  init_seq,
    output sst_pkg::sst_token_t             tok_out,
    output logic                            claim
);

    logic                          entry_valid_reg;
    logic [sst_pkg::ADDR_W-1:0]    entry_address_reg;
    logic [sst_pkg::SEQ_W-1:0]     entry_seq_reg;
    logic [sst_pkg::TS_W-1:0]      entry_next_ts_reg;
    sst_pkg::sst_token_t           tok_reg;
    sst_pkg::sst_token_t           tok_next;

    logic                          active;
    logic                          hit;
    logic                          gap;
    logic [sst_pkg::SEQ_W-1:0]     hit_seq;

    // match against this entry while the token is still unresolved
    assign active  = tok_in.valid && !tok_in.done;
    assign hit     = active && entry_valid_reg && (entry_address_reg == tok_in.address);
    assign claim   = active && !entry_valid_reg;
    assign gap     = (tok_in.timestamp != entry_next_ts_reg) && !tok_in.marker;
    assign hit_seq = entry_seq_reg + {{(sst_pkg::SEQ_W-1){1'b0}}, 1'b1}
                   + {{(sst_pkg::SEQ_W-1){1'b0}}, gap};

    // resolve the token here on a hit or on the first free entry
    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.done    = 1'b1;
            tok_next.created = 1'b0;
            tok_next.seq_num = hit_seq;
        end
        else if (claim)
        begin
            tok_next.done    = 1'b1;
            tok_next.created = 1'b1;
            tok_next.seq_num = init_seq;
        end
    end

    // entry valid bit, set once when the entry is claimed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (claim)
        begin
            entry_valid_reg <= 1'b1;
        end
    end

    // entry contents
    always_ff @(posedge clk)
    begin
        if (claim)
        begin
            entry_address_reg <= tok_in.address;
            entry_seq_reg     <= init_seq;
            entry_next_ts_reg <= tok_in.next_timestamp;
        end
        else if (hit)
        begin
            entry_seq_reg     <= hit_seq;
            entry_next_ts_reg <= tok_in.next_timestamp;
        end
    end

    // token stage toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== sv/stream_sequence_tracker.sv =====
// top level of the stream sequence tracker: cell chain, lfsr and result stage
//
//  channel  direction  handshake                 payload
//  -------  ---------  ------------------------  ---------------------------------------
//  in       input      in_valid / in_ready       source_address, packet_timestamp,
//                                                expected_next_timestamp, marker
//  out      output     out_valid / out_ready     sequence_number, stream_created, table_full
//  cfg      input      cfg_write_en              cfg_write_data (random seed)
//
// one item is in the chain at a time; its result moves one cell per cycle through the
// token stages of all STREAM_ENTRIES cells, then through the pending stage into the
// output register, and in_ready rises in the same cycle that the output register loads.
// a waiting result blocks the next item only while it still sits in the pending stage.
// reset clears all entry valid bits at once and loads the lfsr with 1; no clearing pass.
// a stalled output holds its result; the chain itself never stalls.
`timescale 1ns / 1ps
`default_nettype none

module stream_sequence_tracker #(
    parameter int STREAM_ENTRIES = sst_pkg::STREAM_ENTRIES_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [sst_pkg::LFSR_W-1:0]   cfg_write_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [sst_pkg::ADDR_W-1:0]   source_address,
    input  wire logic [sst_pkg::TS_W-1:0]     packet_timestamp,
    input  wire logic [sst_pkg::TS_W-1:0]     expected_next_timestamp,
    input  wire logic                         marker,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [sst_pkg::SEQ_W-1:0]         sequence_number,
    output logic                              stream_created,
    output logic                              table_full
);

    sst_pkg::sst_token_t            tok_chain [STREAM_ENTRIES+1];
    logic [STREAM_ENTRIES-1:0]      claim_vec;
    logic [STREAM_ENTRIES-1:0]      tok_valid_vec;
    logic                           claim_any;
    logic                           in_xfer;
    logic                           pend_move;
    sst_pkg::sst_token_t            tok_last;

    logic                           busy_reg;
    logic                           pend_valid_reg;
    logic [sst_pkg::SEQ_W-1:0]      pend_seq_reg;
    logic                           pend_new_reg;
    logic                           pend_full_reg;
    logic                           out_valid_reg;
    logic [sst_pkg::SEQ_W-1:0]      out_seq_reg;
    logic                           out_new_reg;
    logic                           out_full_reg;
    logic [sst_pkg::LFSR_W-1:0]     lfsr_reg;
    logic [sst_pkg::LFSR_W-1:0]     lfsr_step;

    assign in_ready = !busy_reg;
    assign in_xfer  = in_valid && in_ready;

    // token entering the chain
    always_comb
    begin
        tok_chain[0]                = '0;
        tok_chain[0].valid          = in_xfer;
        tok_chain[0].address        = source_address;
        tok_chain[0].timestamp      = packet_timestamp;
        tok_chain[0].next_timestamp = expected_next_timestamp;
        tok_chain[0].marker         = marker;
    end

    // galois lfsr step, used as the first sequence number of a new stream
    assign lfsr_step = {1'b0, lfsr_reg[sst_pkg::LFSR_W-1:1]}
                     ^ (lfsr_reg[0] ? sst_pkg::LFSR_TAPS : '0);

    // chain of entry cells
    for (genvar g = 0; g < STREAM_ENTRIES; g++)
    begin : g_cell
        sst_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok_chain[g]),
            .init_seq (lfsr_step[sst_pkg::SEQ_W-1:0]),
            .tok_out  (tok_chain[g+1]),
            .claim    (claim_vec[g])
        );
        assign tok_valid_vec[g] = tok_chain[g+1].valid;
    end

    assign claim_any = |claim_vec;
    assign tok_last  = tok_chain[STREAM_ENTRIES];

    // lfsr: reloaded on a seed write, stepped once per new stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= sst_pkg::LFSR_NONZERO_SEED;
        end
        else if (cfg_write_en)
        begin
            lfsr_reg <= (cfg_write_data == '0) ? sst_pkg::LFSR_NONZERO_SEED : cfg_write_data;
        end
        else if (claim_any)
        begin
            lfsr_reg <= lfsr_step;
        end
    end

    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);

    // busy from acceptance until the result reaches the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            busy_reg <= 1'b1;
        end
        else if (pend_move)
        begin
            busy_reg <= 1'b0;
        end
    end

    // pending result at the end of the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (tok_last.valid)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_last.valid)
        begin
            pend_seq_reg  <= tok_last.done ? tok_last.seq_num : '0;
            pend_new_reg  <= tok_last.created;
            pend_full_reg <= !tok_last.done;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pend_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_move)
        begin
            out_seq_reg  <= pend_seq_reg;
            out_new_reg  <= pend_new_reg;
            out_full_reg <= pend_full_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sequence_number = out_seq_reg;
    assign stream_created  = out_new_reg;
    assign table_full      = out_full_reg;

    // checks
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_valid_vec))
        else $error("more than one token in the cell chain");

    a_single_claim: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(claim_vec))
        else $error("more than one cell claimed an entry");

    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> busy_reg)
        else $error("pending result without an item in progress");

    a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
        tok_last.valid |-> !pend_valid_reg)
        else $error("chain result arrived while pending stage full");

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("lfsr locked at zero");

endmodule

`default_nettype wire
